@@ hdl/stftmp_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and elaboration-time tables for the STFT magnitude/phase block.
// No dependencies; the controller, the datapath and the top level import it.
package stftmp_pkg;

  // Frame geometry.
  localparam int FRAME_LEN       = 512;
  localparam int HOP_LEN         = 128;
  localparam int BINS_PER_RESULT = 5;
  localparam int NUM_BINS        = FRAME_LEN / 2 + 1;
  localparam int LAST_BASE       = ((NUM_BINS - 1) / BINS_PER_RESULT) * BINS_PER_RESULT;

  // Widths.
  localparam int SAMPLE_W = 16;
  localparam int IDX_W    = $clog2(FRAME_LEN);
  localparam int FILL_W   = $clog2(FRAME_LEN + 1);
  localparam int HOP_W    = $clog2(HOP_LEN);
  localparam int BIN_W    = $clog2(NUM_BINS + 1);
  localparam int SLOT_W   = $clog2(BINS_PER_RESULT + 1);
  localparam int TW_W     = 32;
  localparam int PROD_W   = SAMPLE_W + TW_W;
  localparam int ACC_W    = 56;
  localparam int ABS_W    = 55;
  localparam int Q_W      = 29;
  localparam int SQ_W     = 2 * Q_W - 1;
  localparam int RAD_W    = 58;
  localparam int MAG_W    = 25;
  localparam int PH_W     = 16;
  localparam int CX_W     = 45;
  localparam int ANG_W    = 32;
  localparam int FIRST_W  = 8;

  // Iteration counts of the shared units.
  localparam int SQRT_STEPS   = RAD_W / 2;
  localparam int CORDIC_STEPS = 31;
  localparam int STEP_W       = 5;

  // Normalization window for the CORDIC input: larger component in [2^40, 2^41).
  localparam int NORM_LO_BIT = 40;
  localparam int NORM_HI_BIT = 41;

  localparam logic [MAG_W:0] MAG_MAX = {1'b0, {MAG_W{1'b1}}};

  // Q30 angle constants for twiddle generation.
  localparam longint unsigned ONE_Q30     = 64'd1073741824;
  localparam longint unsigned TWO_PI_Q30  = 64'd6746518852;
  localparam longint unsigned PI_Q30      = 64'd3373259426;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  typedef logic signed [TW_W-1:0] tw_arr_t [FRAME_LEN];

  typedef enum logic [3:0] {
    S_IDLE, S_BIN, S_MAC, S_DRAIN, S_PREP, S_SQ1, S_SQ2, S_SQ3,
    S_SQRT, S_NORM, S_CINIT, S_CORDIC, S_STORE, S_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic ready;
    logic accept;
    logic frame_start;
    logic bin_start;
    logic mac_issue;
    logic prep;
    logic sq1;
    logic sq2;
    logic sq3;
    logic sqrt_step;
    logic norm_step;
    logic cinit;
    logic cordic_step;
    logic store;
    logic emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hop_done;
    logic n_last;
    logic mac_idle;
    logic sqrt_last;
    logic norm_done;
    logic cordic_last;
    logic group_full;
    logic grp_last;
    logic out_busy;
  } sts_t;

  // CORDIC arctangent table, 2^32 = 2*pi.
  function automatic logic [ANG_W-1:0] atan_lut(input logic [STEP_W-1:0] i);
    logic [ANG_W-1:0] v;
    case (i)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      5'd24: v = 32'd41;
      5'd25: v = 32'd20;
      5'd26: v = 32'd10;
      5'd27: v = 32'd5;
      5'd28: v = 32'd3;
      5'd29: v = 32'd1;
      5'd30: v = 32'd1;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Twiddle table built at elaboration: truncating Taylor series on the folded angle.
  function automatic tw_arr_t gen_tw(input logic want_sin);
    tw_arr_t tab;
    longint unsigned a;
    longint unsigned term;
    longint cs;
    longint sn;
    logic neg_s;
    logic neg_c;
    logic minus;
    for (int r = 0; r < FRAME_LEN; r++) begin
      a = (TWO_PI_Q30 * 64'(r) + 64'(FRAME_LEN / 2)) / 64'(FRAME_LEN);
      neg_s = 1'b0;
      neg_c = 1'b0;
      cs = longint'(ONE_Q30);
      sn = 0;
      term = ONE_Q30;
      if (a > PI_Q30) begin
        a = (a > TWO_PI_Q30) ? 64'd0 : TWO_PI_Q30 - a;
        neg_s = 1'b1;
      end
      if (a > HALF_PI_Q30) begin
        a = PI_Q30 - a;
        neg_c = 1'b1;
      end
      for (int n = 1; n < 48; n++) begin
        minus = ((n >> 1) & 1) != 0;
        term = ((term * a) >> 30) / 64'(n);
        if ((n & 1) != 0) begin
          sn = minus ? sn - longint'(term) : sn + longint'(term);
        end else begin
          cs = minus ? cs - longint'(term) : cs + longint'(term);
        end
      end
      if (cs < 0) cs = 0;
      if (cs > longint'(ONE_Q30)) cs = longint'(ONE_Q30);
      if (sn < 0) sn = 0;
      if (sn > longint'(ONE_Q30)) sn = longint'(ONE_Q30);
      if (want_sin) begin
        tab[r] = TW_W'(neg_s ? -sn : sn);
      end else begin
        tab[r] = TW_W'(neg_c ? -cs : cs);
      end
    end
    return tab;
  endfunction

endpackage

@@ hdl/stftmp_ctrl.sv @@
`timescale 1ns / 1ps
// Sequencer for the STFT block: walks each frame through accumulate, root, CORDIC and output.
// Depends on stftmp_pkg for the state, command and status types.
module stftmp_ctrl import stftmp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic sample_valid,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (sample_valid && sts.hop_done) state_next = S_BIN;
      S_BIN:    state_next = S_MAC;
      S_MAC:    if (sts.n_last) state_next = S_DRAIN;
      S_DRAIN:  if (sts.mac_idle) state_next = S_PREP;
      S_PREP:   state_next = S_SQ1;
      S_SQ1:    state_next = S_SQ2;
      S_SQ2:    state_next = S_SQ3;
      S_SQ3:    state_next = S_SQRT;
      S_SQRT:   if (sts.sqrt_last) state_next = S_NORM;
      S_NORM:   if (sts.norm_done) state_next = S_CINIT;
      S_CINIT:  state_next = S_CORDIC;
      S_CORDIC: if (sts.cordic_last) state_next = S_STORE;
      S_STORE:  state_next = sts.group_full ? S_EMIT : S_BIN;
      S_EMIT:   if (!sts.out_busy) state_next = sts.grp_last ? S_IDLE : S_BIN;
      default:  state_next = S_IDLE;
    endcase
  end

  // Command decode.
  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        cmd.ready       = 1'b1;
        cmd.accept      = sample_valid;
        cmd.frame_start = sample_valid && sts.hop_done;
      end
      S_BIN:    cmd.bin_start   = 1'b1;
      S_MAC:    cmd.mac_issue   = 1'b1;
      S_DRAIN:  cmd             = '0;
      S_PREP:   cmd.prep        = 1'b1;
      S_SQ1:    cmd.sq1         = 1'b1;
      S_SQ2:    cmd.sq2         = 1'b1;
      S_SQ3:    cmd.sq3         = 1'b1;
      S_SQRT:   cmd.sqrt_step   = 1'b1;
      S_NORM:   cmd.norm_step   = 1'b1;
      S_CINIT:  cmd.cinit       = 1'b1;
      S_CORDIC: cmd.cordic_step = 1'b1;
      S_STORE:  cmd.store       = 1'b1;
      S_EMIT:   cmd.emit        = !sts.out_busy;
      default:  cmd             = '0;
    endcase
  end

endmodule

@@ hdl/stftmp_dp.sv @@
`timescale 1ns / 1ps
// Datapath of the STFT block: sample window, DFT accumulator, square root, CORDIC, output register.
// Depends on stftmp_pkg for widths, tables and the command and status types.
module stftmp_dp import stftmp_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  cmd_t                       cmd,
  output sts_t                       sts,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic                       result_stall,
  output logic                       result_valid,
  output logic [FIRST_W-1:0]         first_bin,
  output logic                       last,
  output logic [MAG_W-1:0]           out_mag [BINS_PER_RESULT],
  output logic signed [PH_W-1:0]     out_ph  [BINS_PER_RESULT]
);

  localparam tw_arr_t COS_ROM = gen_tw(1'b0);
  localparam tw_arr_t SIN_ROM = gen_tw(1'b1);

  // Window storage and write side.
  logic signed [SAMPLE_W-1:0] win_mem [FRAME_LEN];
  logic [IDX_W-1:0]  wp;
  logic [FILL_W-1:0] fill;
  logic [HOP_W-1:0]  hop;

  // Accumulation pipeline.
  logic [IDX_W-1:0]           n;
  logic [IDX_W-1:0]           idx;
  logic [BIN_W-1:0]           k;
  logic                       s1_valid, s1_live, s2_valid;
  logic signed [SAMPLE_W-1:0] win_q;
  logic signed [TW_W-1:0]     cos_q, sin_q;
  logic signed [SAMPLE_W-1:0] smp;
  logic signed [PROD_W-1:0]   prod_re, prod_im;
  logic signed [ACC_W-1:0]    acc_re, acc_im;
  logic [FILL_W:0]            live_sum;

  // Magnitude path.
  logic [ABS_W-1:0] abs_re, abs_im;
  logic [ABS_W-1:0] ux, uy;
  logic             re_neg, im_neg;
  logic [Q_W-1:0]   qr, qi;
  logic [SQ_W-1:0]  sqr, sqi;
  logic [RAD_W-1:0] rad, res, sbit, trial;
  logic [STEP_W-1:0] scnt;
  logic [MAG_W:0]   mag_round;
  logic [MAG_W-1:0] mag_val;

  // Phase path.
  logic [ABS_W-1:0]        mx;
  logic                    too_big, too_small, mx_zero;
  logic signed [CX_W-1:0]  cx, cy, dx, dy, y0;
  logic [ANG_W-1:0]        ang, ang_round;
  logic [STEP_W-1:0]       ccnt;
  logic                    zero_q;
  logic signed [PH_W-1:0]  ph_val;

  // Result grouping.
  logic [MAG_W-1:0]       slot_mag [BINS_PER_RESULT];
  logic signed [PH_W-1:0] slot_ph  [BINS_PER_RESULT];
  logic [SLOT_W-1:0]      slot_cnt, grp_cnt;
  logic [BIN_W-1:0]       grp_base;
  logic                   grp_last;
  logic                   frame_last;

  // Window write, fill count and hop counter.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      win_mem[wp] <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= '0;
      fill <= '0;
      hop  <= '0;
    end else if (cmd.accept) begin
      wp  <= wp + 1'b1;
      hop <= sts.hop_done ? '0 : hop + 1'b1;
      if (fill != FILL_W'(FRAME_LEN)) begin
        fill <= fill + 1'b1;
      end
    end
  end

  // Tap and twiddle index counters.
  always_ff @(posedge clk) begin
    if (cmd.bin_start) begin
      n   <= '0;
      idx <= '0;
    end else if (cmd.mac_issue) begin
      n   <= n + 1'b1;
      idx <= idx + k[IDX_W-1:0];
    end
  end

  // Entries never written read as zero: tap n is live once the fill count plus n reaches the frame length.
  assign live_sum = {1'b0, fill} + (FILL_W + 1)'(n);

  // Read stage: window memory and twiddle ROMs, registered.
  always_ff @(posedge clk) begin
    win_q   <= win_mem[wp + n];
    cos_q   <= COS_ROM[idx];
    sin_q   <= SIN_ROM[idx];
    s1_live <= live_sum >= (FILL_W + 1)'(FRAME_LEN);
  end

  assign smp = s1_live ? win_q : '0;

  // Multiply stage.
  always_ff @(posedge clk) begin
    prod_re <= smp * cos_q;
    prod_im <= smp * sin_q;
  end

  // Accumulate stage.
  always_ff @(posedge clk) begin
    if (cmd.bin_start) begin
      acc_re <= '0;
      acc_im <= '0;
    end else if (s2_valid) begin
      acc_re <= acc_re + ACC_W'(prod_re);
      acc_im <= acc_im - ACC_W'(prod_im);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= cmd.mac_issue;
      s2_valid <= s1_valid;
    end
  end

  // Absolute values.
  assign abs_re = ABS_W'(acc_re[ACC_W-1] ? -acc_re : acc_re);
  assign abs_im = ABS_W'(acc_im[ACC_W-1] ? -acc_im : acc_im);

  // Largest component, for normalization ahead of the CORDIC.
  assign mx        = (ux > uy) ? ux : uy;
  assign too_big   = mx[ABS_W-1:NORM_HI_BIT] != '0;
  assign too_small = mx[ABS_W-1:NORM_LO_BIT] == '0;
  assign mx_zero   = mx == '0;

  // Operand capture, normalization shifts and squares of the rounded components.
  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      ux     <= abs_re;
      uy     <= abs_im;
      re_neg <= acc_re[ACC_W-1];
      im_neg <= acc_im[ACC_W-1];
      qr     <= Q_W'((abs_re + (ABS_W'(1) << 25)) >> 26);
      qi     <= Q_W'((abs_im + (ABS_W'(1) << 25)) >> 26);
    end else if (cmd.norm_step && !mx_zero) begin
      if (too_big) begin
        ux <= ux >> 1;
        uy <= uy >> 1;
      end else if (too_small) begin
        ux <= ux << 1;
        uy <= uy << 1;
      end
    end
    if (cmd.sq1) sqr <= qr * qr;
    if (cmd.sq2) sqi <= qi * qi;
  end

  // Restoring square root, two radicand bits per step.
  assign trial = res + sbit;

  always_ff @(posedge clk) begin
    if (cmd.sq3) begin
      rad  <= RAD_W'(sqr) + RAD_W'(sqi);
      res  <= '0;
      sbit <= RAD_W'(1) << (RAD_W - 2);
      scnt <= '0;
    end else if (cmd.sqrt_step) begin
      if (rad >= trial) begin
        rad <= rad - trial;
        res <= (res >> 1) + sbit;
      end else begin
        res <= res >> 1;
      end
      sbit <= sbit >> 2;
      scnt <= scnt + 1'b1;
    end
  end

  assign mag_round = (MAG_W + 1)'((res + RAD_W'(8)) >> 4);
  assign mag_val   = (mag_round > MAG_MAX) ? MAG_MAX[MAG_W-1:0] : mag_round[MAG_W-1:0];

  // CORDIC vectoring, one micro-rotation per cycle.
  assign y0 = im_neg ? -$signed(CX_W'(uy)) : $signed(CX_W'(uy));
  assign dx = cy >>> ccnt;
  assign dy = cx >>> ccnt;

  always_ff @(posedge clk) begin
    if (cmd.cinit) begin
      cx     <= $signed(CX_W'(ux));
      cy     <= re_neg ? -y0 : y0;
      ang    <= re_neg ? {1'b1, {(ANG_W - 1){1'b0}}} : '0;
      ccnt   <= '0;
      zero_q <= mx_zero;
    end else if (cmd.cordic_step) begin
      if (cy > 0) begin
        cx  <= cx + dx;
        cy  <= cy - dy;
        ang <= ang + atan_lut(ccnt);
      end else begin
        cx  <= cx - dx;
        cy  <= cy + dy;
        ang <= ang - atan_lut(ccnt);
      end
      ccnt <= ccnt + 1'b1;
    end
  end

  assign ang_round = ang + ANG_W'(32'h8000);
  assign ph_val    = zero_q ? '0 : $signed(ang_round[ANG_W-1:ANG_W-PH_W]);

  // Bin counter and grouping of finished bins.
  assign frame_last = k == BIN_W'(NUM_BINS - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      k        <= '0;
      slot_cnt <= '0;
      grp_cnt  <= '0;
      grp_last <= 1'b0;
    end else if (cmd.frame_start) begin
      k        <= '0;
      slot_cnt <= '0;
    end else if (cmd.store) begin
      k <= k + 1'b1;
      if (sts.group_full) begin
        slot_cnt <= '0;
        grp_cnt  <= slot_cnt + 1'b1;
        grp_last <= frame_last;
      end else begin
        slot_cnt <= slot_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      slot_mag[slot_cnt] <= mag_val;
      slot_ph[slot_cnt]  <= ph_val;
      if (slot_cnt == '0) begin
        grp_base <= k;
      end
    end
  end

  // Output register; slots beyond the group's count read as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      first_bin <= grp_base[FIRST_W-1:0];
      last      <= grp_last;
      for (int i = 0; i < BINS_PER_RESULT; i++) begin
        out_mag[i] <= (SLOT_W'(i) < grp_cnt) ? slot_mag[i] : '0;
        out_ph[i]  <= (SLOT_W'(i) < grp_cnt) ? slot_ph[i]  : '0;
      end
    end
  end

  // Status to the controller.
  always_comb begin
    sts.hop_done    = hop == HOP_W'(HOP_LEN - 1);
    sts.n_last      = n == IDX_W'(FRAME_LEN - 1);
    sts.mac_idle    = !s1_valid && !s2_valid;
    sts.sqrt_last   = scnt == STEP_W'(SQRT_STEPS - 1);
    sts.norm_done   = mx_zero || (!too_big && !too_small);
    sts.cordic_last = ccnt == STEP_W'(CORDIC_STEPS - 1);
    sts.group_full  = (slot_cnt == SLOT_W'(BINS_PER_RESULT - 1)) || frame_last;
    sts.grp_last    = grp_last;
    sts.out_busy    = result_valid;
  end

endmodule

@@ hdl/stft_magnitude_phase.sv @@
`timescale 1ns / 1ps
// Top level of the STFT magnitude/phase block: sequencer plus datapath.
// Depends on stftmp_pkg, stftmp_ctrl and stftmp_dp.
//
//   Channel  Direction  Handshake                     Payload
//   sample   in         sample_valid / sample_stall   sample[15:0] signed
//   result   out        result_valid / result_stall   first_bin, last, magnitude_0..4, phase_0..4
//
// A sample that does not finish a hop is only written to the window. A sample that finishes a
// hop starts a frame: each of the 257 bins is accumulated over all 512 taps on one multiply
// pair, then drained, squared, rooted, normalized and rotated by the CORDIC; the frame time is
// set by the single multiply-accumulate over the window memory. sample_stall is high for the
// whole frame. Reset is synchronous; the window reads as zero until filled, with no clearing.
// A stalled result holds and the next group waits in the slot registers.
module stft_magnitude_phase import stftmp_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       sample_valid,
  output logic                       sample_stall,
  input  logic signed [SAMPLE_W-1:0] sample,
  output logic                       result_valid,
  input  logic                       result_stall,
  output logic [FIRST_W-1:0]         first_bin,
  output logic                       last,
  output logic [MAG_W-1:0]           magnitude_0,
  output logic [MAG_W-1:0]           magnitude_1,
  output logic [MAG_W-1:0]           magnitude_2,
  output logic [MAG_W-1:0]           magnitude_3,
  output logic [MAG_W-1:0]           magnitude_4,
  output logic signed [PH_W-1:0]     phase_0,
  output logic signed [PH_W-1:0]     phase_1,
  output logic signed [PH_W-1:0]     phase_2,
  output logic signed [PH_W-1:0]     phase_3,
  output logic signed [PH_W-1:0]     phase_4
);

  cmd_t                   cmd;
  sts_t                   sts;
  logic [MAG_W-1:0]       out_mag [BINS_PER_RESULT];
  logic signed [PH_W-1:0] out_ph  [BINS_PER_RESULT];

  stftmp_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sts          (sts),
    .cmd          (cmd)
  );

  stftmp_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .sample       (sample),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .first_bin    (first_bin),
    .last         (last),
    .out_mag      (out_mag),
    .out_ph       (out_ph)
  );

  assign sample_stall = !cmd.ready;

  assign magnitude_0 = out_mag[0];
  assign magnitude_1 = out_mag[1];
  assign magnitude_2 = out_mag[2];
  assign magnitude_3 = out_mag[3];
  assign magnitude_4 = out_mag[4];
  assign phase_0     = out_ph[0];
  assign phase_1     = out_ph[1];
  assign phase_2     = out_ph[2];
  assign phase_3     = out_ph[3];
  assign phase_4     = out_ph[4];

  // A transaction that completes a hop must start a frame and block further samples.
  a_frame_starts: assert property (@(posedge clk) disable iff (rst)
    sample_valid && !sample_stall && sts.hop_done |=> sample_stall)
    else $error("frame did not start after the hop completed");

  // The final result of a frame carries the last group's base bin.
  a_last_base: assert property (@(posedge clk) disable iff (rst)
    result_valid && last |-> first_bin == FIRST_W'(LAST_BASE))
    else $error("last flag on a group other than the final one");

  // Earlier groups never reach the final base bin.
  a_not_last_base: assert property (@(posedge clk) disable iff (rst)
    result_valid && !last |-> first_bin < FIRST_W'(LAST_BASE))
    else $error("group past the final base without the last flag");

endmodule
